### src/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies cons in the same cycle
`define CHK_SAME(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that cond implies cons in the next cycle
`define CHK_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/nnr_pkg.sv
package nnr_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(NUM_BITS + 1);
  localparam logic [WORD_BITS-1:0] MAXV   = '1;
  localparam logic [WORD_BITS-1:0] FX_ONE = WORD_BITS'(1) << FRAC_BITS;
  localparam logic [7:0] RESET_LIMIT = 8'd100;
  localparam logic [3:0] MAX_DEGREE  = 4'd8;
endpackage

### src/newton_nth_root_top.sv
// Newton nth root of an unsigned Q16.16 radicand for degrees 1 to 8 (0 acts as 1,
// above 8 as 8), starting from a guess of 1.0. One item is worked at a time on a
// shared 32x32 multiplier and a one-bit-per-cycle restoring divider. Each Newton
// iteration runs (degree-1) multiply steps, then a/guess^(n-1) (one load step and
// 48 quotient steps, set directly when the power is zero), one sum step and 48
// quotient steps for the division by the degree; an item runs iterations_used of
// them. The iteration limit comes out of reset at 100 iterations.
// The result waits in an output register so the next item can be taken meanwhile.
module newton_nth_root_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_radicand,
  input  logic [3:0]  in_degree,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_root,
  output logic        out_converged,
  output logic [7:0]  out_iterations_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_iteration_limit
);
  localparam int W  = nnr_pkg::WORD_BITS;
  localparam int NB = nnr_pkg::NUM_BITS;
  localparam int CB = nnr_pkg::CNT_BITS;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_QDIV, S_SUM, S_NDIV, S_FIN} state_t;

  state_t        state_r, state_nxt;
  logic [7:0]    limit_r, limit_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [3:0]    n_r, n_nxt;
  logic [7:0]    lim_r, lim_nxt;
  logic [W-1:0]  guess_r, guess_nxt;
  logic [W-1:0]  prev_r, prev_nxt;
  logic [7:0]    used_r, used_nxt;
  logic          conv_r, conv_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [W-1:0]  p_r, p_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [NB-1:0] num_r, num_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic          ovf_r, ovf_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CB-1:0] dcnt_r, dcnt_nxt;
  logic          ov_r, ov_nxt;
  logic [W-1:0]  oroot_r, oroot_nxt;
  logic          oconv_r, oconv_nxt;
  logic [7:0]    oused_r, oused_nxt;

  logic          in_xfer, out_free;
  logic [2*W-1:0] prod;
  logic [W-1:0]  mul_res;
  logic [W:0]    rem_sh;
  logic          qbit;
  logic [W:0]    rem_step;
  logic [W-1:0]  q_step;
  logic          ovf_step;
  logic [3:0]    nm1;
  logic [W+3:0]  sum1;
  logic [W-1:0]  sat1;
  logic [W:0]    sum2;
  logic [W-1:0]  sat2;
  logic [3:0]    deg_in;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_root  = oroot_r;
  assign out_converged = oconv_r;
  assign out_iterations_used = oused_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !ov_r || !out_stall;

  // Saturating fixed-point multiply
  assign prod    = (2*W)'(p_r) * (2*W)'(guess_r);
  assign mul_res = (prod[2*W-1:W+nnr_pkg::FRAC_BITS] != '0) ? nnr_pkg::MAXV :
                   prod[W+nnr_pkg::FRAC_BITS-1:nnr_pkg::FRAC_BITS];

  // One restoring division step
  assign rem_sh   = {rem_r[W-1:0], num_r[NB-1]};
  assign qbit     = (rem_sh >= {1'b0, d_r});
  assign rem_step = qbit ? (rem_sh - {1'b0, d_r}) : rem_sh;
  assign q_step   = {q_r[W-2:0], qbit};
  assign ovf_step = ovf_r | q_r[W-1];

  // Weighted sum, saturated
  assign nm1  = n_r - 4'd1;
  assign sum1 = (W+4)'(nm1) * (W+4)'(guess_r);
  assign sat1 = (sum1 > (W+4)'(nnr_pkg::MAXV)) ? nnr_pkg::MAXV : sum1[W-1:0];
  assign sum2 = {1'b0, sat1} + {1'b0, quo_r};
  assign sat2 = sum2[W] ? nnr_pkg::MAXV : sum2[W-1:0];

  // Clamp degree
  always_comb begin
    if (in_degree == 4'd0) begin
      deg_in = 4'd1;
    end else if (in_degree > nnr_pkg::MAX_DEGREE) begin
      deg_in = nnr_pkg::MAX_DEGREE;
    end else begin
      deg_in = in_degree;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    limit_nxt = cfg_valid ? cfg_iteration_limit : limit_r;
    a_nxt = a_r; n_nxt = n_r; lim_nxt = lim_r;
    guess_nxt = guess_r; prev_nxt = prev_r; used_nxt = used_r; conv_nxt = conv_r;
    k_nxt = k_r; p_nxt = p_r; quo_nxt = quo_r;
    num_nxt = num_r; rem_nxt = rem_r; q_nxt = q_r; ovf_nxt = ovf_r;
    d_nxt = d_r; dcnt_nxt = dcnt_r;
    ov_nxt = ov_r; oroot_nxt = oroot_r; oconv_nxt = oconv_r; oused_nxt = oused_r;

    // drop the result once taken
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          a_nxt     = in_radicand;
          n_nxt     = deg_in;
          lim_nxt   = (limit_r == 8'd0) ? 8'd1 : limit_r;
          guess_nxt = nnr_pkg::FX_ONE;
          used_nxt  = 8'd0;
          conv_nxt  = 1'b0;
          p_nxt     = nnr_pkg::FX_ONE;
          k_nxt     = 3'(deg_in - 4'd1);
          state_nxt = (deg_in == 4'd1) ? S_QDIV : S_MUL;
        end
      end
      S_MUL: begin
        p_nxt = mul_res;
        k_nxt = k_r - 3'd1;
        if (k_r == 3'd1) begin
          state_nxt = S_QDIV;
        end
      end
      S_QDIV: begin
        // load the quotient a/p
        if (p_r == '0) begin
          quo_nxt   = (a_r == '0) ? '0 : nnr_pkg::MAXV;
          state_nxt = S_SUM;
        end else if (dcnt_r == '0) begin
          num_nxt  = {a_r, {nnr_pkg::FRAC_BITS{1'b0}}};
          rem_nxt  = '0;
          q_nxt    = '0;
          ovf_nxt  = 1'b0;
          d_nxt    = p_r;
          dcnt_nxt = CB'(NB);
        end else begin
          num_nxt  = {num_r[NB-2:0], 1'b0};
          rem_nxt  = rem_step;
          q_nxt    = q_step;
          ovf_nxt  = ovf_step;
          dcnt_nxt = dcnt_r - CB'(1);
          if (dcnt_r == CB'(1)) begin
            quo_nxt   = ovf_step ? nnr_pkg::MAXV : q_step;
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        num_nxt   = NB'(sat2);
        rem_nxt   = '0;
        q_nxt     = '0;
        ovf_nxt   = 1'b0;
        d_nxt     = W'(n_r);
        dcnt_nxt  = CB'(NB);
        state_nxt = S_NDIV;
      end
      S_NDIV: begin
        num_nxt  = {num_r[NB-2:0], 1'b0};
        rem_nxt  = rem_step;
        q_nxt    = q_step;
        dcnt_nxt = dcnt_r - CB'(1);
        if (dcnt_r == CB'(1)) begin
          guess_nxt = q_step;
          used_nxt  = used_r + 8'd1;
          prev_nxt  = q_step;
          p_nxt     = nnr_pkg::FX_ONE;
          k_nxt     = 3'(n_r - 4'd1);
          if (q_step == '0) begin
            state_nxt = S_FIN;
          end else if (used_r != 8'd0 && q_step == prev_r) begin
            conv_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else if (used_r + 8'd1 >= lim_r) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = (n_r == 4'd1) ? S_QDIV : S_MUL;
          end
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          ov_nxt    = 1'b1;
          oroot_nxt = guess_r;
          oconv_nxt = conv_r;
          oused_nxt = used_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= nnr_pkg::RESET_LIMIT;
      ov_r    <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      limit_r <= limit_nxt;
      ov_r    <= ov_nxt;
      dcnt_r  <= dcnt_nxt;
    end
    a_r <= a_nxt; n_r <= n_nxt; lim_r <= lim_nxt;
    guess_r <= guess_nxt; prev_r <= prev_nxt; used_r <= used_nxt; conv_r <= conv_nxt;
    k_r <= k_nxt; p_r <= p_nxt; quo_r <= quo_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; q_r <= q_nxt; ovf_r <= ovf_nxt; d_r <= d_nxt;
    oroot_r <= oroot_nxt; oconv_r <= oconv_nxt; oused_r <= oused_nxt;
  end
endmodule

### src/nnr_chk.sv
`include "assert_macros.svh"

module nnr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_root,
  input logic        out_converged,
  input logic [7:0]  out_iterations_used
);
  // a stalled result stays offered
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // every result reports at least one iteration
  `CHK_SAME(a_used_nz, clk, rst_n, out_valid, out_iterations_used != 8'd0)
  // convergence needs two iterations and a nonzero root
  `CHK_SAME(a_conv_two, clk, rst_n, out_valid && out_converged,
            out_iterations_used >= 8'd2 && out_root != 32'd0)
  // the block is busy right after a transfer in
  `CHK_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind newton_nth_root_top nnr_chk u_nnr_chk (.*);

### verif/newton_nth_root_top_test.sv
`timescale 1ns / 1ps

module newton_nth_root_top_test;

  typedef struct {
    logic [31:0] root;
    logic        converged;
    logic [7:0]  iterations_used;
  } root_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_radicand;
  logic [3:0]  in_degree;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_root;
  logic        out_converged;
  logic [7:0]  out_iterations_used;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_iteration_limit;

  root_result_t pending_roots[$];
  logic [7:0]   model_limit;
  int           error_count;
  bit           quiet;

  newton_nth_root_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_radicand(in_radicand),
    .in_degree(in_degree),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_root(out_root),
    .out_converged(out_converged),
    .out_iterations_used(out_iterations_used),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_iteration_limit(cfg_iteration_limit)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Newton iteration from 1.0 with truncating, saturating fixed-point steps
  function automatic root_result_t predict_root(logic [31:0] a_in, logic [3:0] deg_in);
    logic [63:0]  a, n, guess, prev, p, quo, sum;
    int unsigned  lim, used, k;
    bit           conv;
    root_result_t r;
    a = {32'd0, a_in};
    n = (deg_in == 4'd0) ? 64'd1 :
        (deg_in > nnr_pkg::MAX_DEGREE) ? 64'(nnr_pkg::MAX_DEGREE) : 64'(deg_in);
    lim = (model_limit == 8'd0) ? 1 : model_limit;
    guess = 64'(nnr_pkg::FX_ONE);
    prev = 64'd0;
    used = 0;
    conv = 1'b0;
    while (used < lim) begin
      p = 64'(nnr_pkg::FX_ONE);
      for (k = 1; k < n; k++) begin
        p = (p * guess) >> nnr_pkg::FRAC_BITS;
        if (p > 64'(nnr_pkg::MAXV)) p = 64'(nnr_pkg::MAXV);
      end
      if (p == 64'd0) quo = (a == 64'd0) ? 64'd0 : 64'(nnr_pkg::MAXV);
      else begin
        quo = (a << nnr_pkg::FRAC_BITS) / p;
        if (quo > 64'(nnr_pkg::MAXV)) quo = 64'(nnr_pkg::MAXV);
      end
      sum = (n - 64'd1) * guess;
      if (sum > 64'(nnr_pkg::MAXV)) sum = 64'(nnr_pkg::MAXV);
      sum = sum + quo;
      if (sum > 64'(nnr_pkg::MAXV)) sum = 64'(nnr_pkg::MAXV);
      guess = sum / n;
      used++;
      if (guess == 64'd0) break;
      if (used >= 2 && guess == prev) begin
        conv = 1'b1;
        break;
      end
      prev = guess;
    end
    r.root = guess[31:0];
    r.converged = conv;
    r.iterations_used = used[7:0];
    return r;
  endfunction

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    root_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_roots.size() == 0) begin
        $error("unexpected result root %h", out_root);
        error_count++;
      end else begin
        want = pending_roots.pop_front();
        if (out_root !== want.root) begin
          $error("root: expected %h actual %h", want.root, out_root);
          error_count++;
        end
        if (out_converged !== want.converged) begin
          $error("converged: expected %0d actual %0d", want.converged, out_converged);
          error_count++;
        end
        if (out_iterations_used !== want.iterations_used) begin
          $error("iterations_used: expected %0d actual %0d",
                 want.iterations_used, out_iterations_used);
          error_count++;
        end
      end
    end
  end

  // Stall the result side at random, mostly short, sometimes long
  initial begin
    int span;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 99) < 25) begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (span) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return;
    if (r < 90) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(20, 200)) @(negedge clk);
  endtask

  // Present one item; record its prediction on transfer
  task automatic send_root_request(logic [31:0] radicand, logic [3:0] degree);
    root_result_t want;
    sender_gap();
    @(negedge clk);
    want = predict_root(radicand, degree);
    in_valid <= 1'b1;
    in_radicand <= radicand;
    in_degree <= degree;
    do @(posedge clk); while (in_stall);
    pending_roots.push_back(want);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_roots.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(logic [7:0] limit);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_iteration_limit <= limit;
    do @(posedge clk); while (!cfg_ready);
    model_limit = limit;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    int d;
    send_root_request(32'd0, 4'd2);
    send_root_request(32'hFFFF_FFFF, 4'd2);
    send_root_request(32'h0001_0000, 4'd3);
    send_root_request(32'h0004_0000, 4'd2);
    send_root_request(32'h001B_0000, 4'd3);
    send_root_request(32'd1, 4'd8);
    send_root_request(32'h8000_0000, 4'd1);
    send_root_request(32'hFFFF_FFFF, 4'd8);
    send_root_request(32'd0, 4'd8);
    send_root_request(32'h0000_0100, 4'd4);
    // degree zero and degrees above eight are clamped
    send_root_request(32'h0009_0000, 4'd0);
    send_root_request(32'h0100_0000, 4'd9);
    send_root_request(32'h0100_0000, 4'd15);
    for (d = 1; d <= 8; d++) send_root_request(32'h0123_4567, 4'(d));
  endtask

  function automatic logic [31:0] pick_radicand();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 32'h0003_FFFF);
      1: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random(int count, bit with_pause);
    int i;
    logic [3:0] deg;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        deg = 4'($urandom_range(9, 15)) & {4{$urandom_range(0, 1) == 1}};
      else deg = 4'($urandom_range(1, 8));
      send_root_request(pick_radicand(), deg);
      // hold off until every outstanding root is back
      if (with_pause && i == count / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_radicand = '0;
    in_degree = '0;
    cfg_valid = 1'b0;
    cfg_iteration_limit = '0;
    error_count = 0;
    quiet = 1'b0;
    model_limit = nnr_pkg::RESET_LIMIT;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    write_limit(8'd255);
    test_random(12, 1'b0);
    write_limit(8'd1);
    quiet = 1'b1;
    test_random(25, 1'b0);
    quiet = 1'b0;
    write_limit(8'd0);
    test_random(10, 1'b0);
    write_limit(8'd12);
    test_random(45, 1'b1);
    write_limit(8'd100);
    test_random(55, 1'b0);

    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
